FILE: rtl/gecq_pkg.sv
package gecq_pkg;

	// One cell entry: chain, first edge, one past the last edge
	typedef struct packed {
		logic [5:0]  chain;
		logic [15:0] rstart;
		logic [16:0] rend;
	} entry_t;

	localparam int ENTRY_W = 39;

	// Command codes
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Add status codes
	localparam logic [1:0] ST_APPENDED = 2'd0;
	localparam logic [1:0] ST_MERGED   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BAD      = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] CFG_WIDTH    = 2'd2;
	localparam logic [1:0] CFG_HEIGHT   = 2'd3;

	// Chain slot value that marks a chain not yet gathered
	localparam logic [6:0] SLOT_FREE = 7'h40;

	// Cell coordinate width after subtracting the origin
	localparam int COORD_W = 26;

	localparam logic [6:0] GRID_DIM_MAX = 7'd64;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PUT,
		A_FILL,
		A_SCAN,
		Q_CLAMP,
		Q_START,
		Q_CELL,
		Q_FILL,
		Q_ENT,
		Q_SLOT,
		Q_MRG,
		Q_OUT,
		Q_EWAIT,
		Q_EMIT
	} state_t;

endpackage

FILE: rtl/gecq_ram.sv
module gecq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/grid_edge_chain_query_unit.sv
// Uniform grid of cells, 2**CELL_SHIFT box units on a side, holding (chain,
// edge range) entries. One item is worked at a time. An add reads the cell
// fill count and then scans the cell's entries one at a time through the
// single read port of the entry memory; a bad cell skips both. A query
// clamps the box, then for each covered cell reads its fill count and, for
// each entry found, the entry and its chain slot, plus a gathered read when
// the chain merges, then emits the result words; all of it depends on the box
// and the table contents. After reset a clearing pass empties every cell and
// frees every chain slot; no word is accepted until it ends. Configuration
// writes are taken at any time.
module grid_edge_chain_query_unit #(
	parameter int GRID_CELLS   = 4096,
	parameter int CELL_ENTRIES = 16,
	parameter int MAX_CHAINS   = 64,
	parameter int CELL_SHIFT   = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [13:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [11:0]        cell_index,
	input  logic [5:0]         chain_in,
	input  logic [15:0]        edge_index,
	input  logic signed [23:0] box_min_x,
	input  logic signed [23:0] box_min_y,
	input  logic signed [23:0] box_max_x,
	input  logic signed [23:0] box_max_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         chain_out,
	output logic [15:0]        range_start,
	output logic [16:0]        range_end,
	output logic               found,
	output logic [1:0]         status,
	output logic               last
);
	import gecq_pkg::*;

	localparam int FAW   = $clog2(GRID_CELLS);
	localparam int EAW   = $clog2(GRID_CELLS * CELL_ENTRIES);
	localparam int FW    = $clog2(CELL_ENTRIES + 1);
	localparam int GAW   = $clog2(MAX_CHAINS);
	localparam int KW    = $clog2(MAX_CHAINS + 1);
	localparam int CLR_N = GRID_CELLS > 64 ? GRID_CELLS : 64;
	localparam int CLRW  = $clog2(CLR_N);
	localparam logic signed [24:0] CEIL_ADD = 25'((1 << CELL_SHIFT) - 1);

	typedef struct packed {
		logic       empty;
		logic [6:0] lo;
		logic [6:0] hi;
	} axis_t;

	// Clamp a written grid dimension to 1..64
	function automatic logic [6:0] clamp_dim(input logic [13:0] v);
		logic [6:0] d;
		d = v[6:0];
		if (d == 7'd0) begin
			return 7'd1;
		end
		if (d > GRID_DIM_MAX) begin
			return GRID_DIM_MAX;
		end
		return d;
	endfunction

	// Widen a zero extent, clamp to the grid and flag an empty axis
	function automatic axis_t clamp_axis(input logic signed [COORD_W-1:0] v0,
					     input logic signed [COORD_W-1:0] v1,
					     input logic [6:0] lim);
		logic signed [COORD_W:0] a0;
		logic signed [COORD_W:0] a1;
		logic signed [COORD_W:0] lo;
		logic signed [COORD_W:0] hi;
		logic signed [COORD_W:0] lw;
		axis_t r;
		a0 = {v0[COORD_W-1], v0};
		a1 = {v1[COORD_W-1], v1};
		lw = $signed({{(COORD_W - 6){1'b0}}, lim});
		if (a0 == a1) begin
			a0 = a0 - 1;
			a1 = a1 + 1;
		end
		lo = (a0 < 0) ? '0 : a0;
		hi = (a1 > lw) ? lw : a1;
		r.empty = (lo >= hi);
		r.lo = lo[6:0];
		r.hi = hi[6:0];
		return r;
	endfunction

	function automatic logic [EAW-1:0] eaddr(input logic [12:0] c, input int i);
		return EAW'(32'(c) * CELL_ENTRIES + i);
	endfunction

	// State and registers
	state_t state_q, state_d;
	logic [CLRW-1:0] clr_q, clr_d;
	logic signed [13:0] ox_q, oy_q;
	logic [6:0] w_q, h_q;
	logic [12:0] cell_q, cell_d;
	logic [5:0] chain_q, chain_d;
	logic [15:0] edge_q, edge_d;
	logic [FW-1:0] n_q, n_d, i_q, i_d;
	logic [KW-1:0] cnt_q, cnt_d, k_q, k_d;
	logic [GAW-1:0] s_q, s_d;
	entry_t ent_q, ent_d;
	logic signed [COORD_W-1:0] x0_q, x1_q, y0_q, y1_q, x0_d, x1_d, y0_d, y1_d;
	logic [6:0] xlo_q, xhi_q, ylo_q, yhi_q, x_q, y_q;
	logic [6:0] xlo_d, xhi_d, ylo_d, yhi_d, x_d, y_d;
	logic [12:0] row_q, row_d;
	logic [5:0] pchain_q, pchain_d;
	logic [15:0] pstart_q, pstart_d;
	logic [16:0] pend_q, pend_d;
	logic [1:0] pstat_q, pstat_d;

	logic out_valid_q;
	logic [5:0] chain_out_q, ochain_d;
	logic [15:0] range_start_q, ostart_d;
	logic [16:0] range_end_q, oend_d;
	logic found_q, ofound_d;
	logic [1:0] status_q, ostat_d;
	logic last_q, olast_d;
	logic out_load;

	// Memory ports
	logic fill_we;
	logic [FAW-1:0] fill_waddr, fill_raddr;
	logic [FW-1:0] fill_wdata, fill_rdata;
	logic ent_we;
	logic [EAW-1:0] ent_waddr, ent_raddr;
	entry_t ent_wdata, ent_rdata;
	logic slot_we;
	logic [5:0] slot_waddr, slot_raddr;
	logic [6:0] slot_wdata, slot_rdata;
	logic gath_we;
	logic [GAW-1:0] gath_waddr, gath_raddr;
	entry_t gath_wdata, gath_rdata;

	gecq_ram #(.WIDTH(FW), .DEPTH(GRID_CELLS)) u_fill (
		.clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
		.raddr(fill_raddr), .rdata(fill_rdata)
	);
	gecq_ram #(.WIDTH(ENTRY_W), .DEPTH(GRID_CELLS * CELL_ENTRIES)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata)
	);
	gecq_ram #(.WIDTH(7), .DEPTH(64)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);
	gecq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CHAINS)) u_gath (
		.clk(clk), .we(gath_we), .waddr(gath_waddr), .wdata(gath_wdata),
		.raddr(gath_raddr), .rdata(gath_rdata)
	);

	// Box corners in cells and the origin, widened for subtracting
	logic signed [24:0] bx0, by0, bx1, by1;
	logic signed [COORD_W-1:0] fx0, fy0, cx1, cy1, oxe, oye;
	always_comb begin
		bx0 = $signed({box_min_x[23], box_min_x}) >>> CELL_SHIFT;
		by0 = $signed({box_min_y[23], box_min_y}) >>> CELL_SHIFT;
		bx1 = ($signed({box_max_x[23], box_max_x}) + CEIL_ADD) >>> CELL_SHIFT;
		by1 = ($signed({box_max_y[23], box_max_y}) + CEIL_ADD) >>> CELL_SHIFT;
		fx0 = {bx0[24], bx0};
		fy0 = {by0[24], by0};
		cx1 = {bx1[24], bx1};
		cy1 = {by1[24], by1};
		oxe = {{(COORD_W - 14){ox_q[13]}}, ox_q};
		oye = {{(COORD_W - 14){oy_q[13]}}, oy_q};
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Next state, memory control and register updates
	always_comb begin
		logic [FW-1:0] n;
		logic [12:0] qcell;
		logic nent;
		logic adv;
		axis_t ax;
		axis_t ay;
		entry_t m;
		logic [16:0] e1;

		state_d = state_q;
		clr_d = clr_q;
		cell_d = cell_q;
		chain_d = chain_q;
		edge_d = edge_q;
		n_d = n_q;
		i_d = i_q;
		cnt_d = cnt_q;
		k_d = k_q;
		s_d = s_q;
		ent_d = ent_q;
		x0_d = x0_q; x1_d = x1_q; y0_d = y0_q; y1_d = y1_q;
		xlo_d = xlo_q; xhi_d = xhi_q; ylo_d = ylo_q; yhi_d = yhi_q;
		x_d = x_q; y_d = y_q; row_d = row_q;
		pchain_d = pchain_q; pstart_d = pstart_q; pend_d = pend_q; pstat_d = pstat_q;
		out_load = 1'b0;
		ochain_d = '0; ostart_d = '0; oend_d = '0;
		ofound_d = 1'b0; ostat_d = ST_APPENDED; olast_d = 1'b1;
		fill_we = 1'b0; fill_waddr = FAW'(cell_q); fill_wdata = '0;
		fill_raddr = FAW'(cell_q);
		ent_we = 1'b0; ent_waddr = '0; ent_wdata = ent_q; ent_raddr = '0;
		slot_we = 1'b0; slot_waddr = ent_q.chain; slot_wdata = SLOT_FREE;
		slot_raddr = ent_rdata.chain;
		gath_we = 1'b0; gath_waddr = GAW'(cnt_q); gath_wdata = ent_q;
		gath_raddr = GAW'(k_q);
		n = (32'(fill_rdata) > CELL_ENTRIES) ? FW'(CELL_ENTRIES) : fill_rdata;
		qcell = row_q + {6'b0, x_q};
		nent = 1'b0;
		adv = 1'b0;
		e1 = {1'b0, edge_q} + 17'd1;
		m = gath_rdata;
		ax = clamp_axis(x0_q, x1_q, w_q);
		ay = clamp_axis(y0_q, y1_q, h_q);

		unique case (state_q)
			S_CLEAR: begin
				// Empty every cell and free every chain slot
				fill_we = (32'(clr_q) < GRID_CELLS);
				fill_waddr = FAW'(clr_q);
				slot_we = (32'(clr_q) < 64);
				slot_waddr = 6'(clr_q);
				if (32'(clr_q) == CLR_N - 1) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cell_d = {1'b0, cell_index};
					chain_d = chain_in;
					edge_d = edge_index;
					if (command == CMD_QUERY) begin
						x0_d = fx0 - oxe;
						y0_d = fy0 - oye;
						x1_d = cx1 - oxe;
						y1_d = cy1 - oye;
						cnt_d = '0;
						state_d = Q_CLAMP;
					end else if (32'(cell_index) >= 32'(w_q) * 32'(h_q) ||
						     32'(cell_index) >= GRID_CELLS) begin
						pchain_d = chain_in;
						pstart_d = '0;
						pend_d = '0;
						pstat_d = ST_BAD;
						state_d = S_PUT;
					end else begin
						fill_raddr = FAW'(cell_index);
						state_d = A_FILL;
					end
				end
			end
			S_PUT: begin
				// Hand the pending word to the output register
				if (out_free) begin
					out_load = 1'b1;
					ochain_d = pchain_q;
					ostart_d = pstart_q;
					oend_d = pend_q;
					ostat_d = pstat_q;
					state_d = S_IDLE;
				end
			end
			A_FILL: begin
				n_d = n;
				i_d = '0;
				if (n == '0) begin
					ent_we = 1'b1;
					ent_waddr = eaddr(cell_q, 0);
					ent_wdata = '{chain: chain_q, rstart: edge_q, rend: e1};
					fill_we = 1'b1;
					fill_wdata = FW'(1);
					pchain_d = chain_q; pstart_d = edge_q; pend_d = e1;
					pstat_d = ST_APPENDED;
					state_d = S_PUT;
				end else begin
					ent_raddr = eaddr(cell_q, 0);
					state_d = A_SCAN;
				end
			end
			A_SCAN: begin
				pchain_d = chain_q;
				if (ent_rdata.chain == chain_q) begin
					// Widen the matching entry
					m = ent_rdata;
					if (edge_q < m.rstart) begin
						m.rstart = edge_q;
					end
					if (e1 > m.rend) begin
						m.rend = e1;
					end
					ent_we = 1'b1;
					ent_waddr = eaddr(cell_q, 32'(i_q));
					ent_wdata = m;
					pstart_d = m.rstart; pend_d = m.rend;
					pstat_d = ST_MERGED;
					state_d = S_PUT;
				end else if (32'(i_q) + 1 < 32'(n_q)) begin
					i_d = i_q + 1'b1;
					ent_raddr = eaddr(cell_q, 32'(i_q) + 1);
				end else if (32'(n_q) >= CELL_ENTRIES) begin
					pstart_d = '0; pend_d = '0;
					pstat_d = ST_FULL;
					state_d = S_PUT;
				end else begin
					// Append a new entry at the end of the cell
					ent_we = 1'b1;
					ent_waddr = eaddr(cell_q, 32'(n_q));
					ent_wdata = '{chain: chain_q, rstart: edge_q, rend: e1};
					fill_we = 1'b1;
					fill_wdata = n_q + 1'b1;
					pstart_d = edge_q; pend_d = e1;
					pstat_d = ST_APPENDED;
					state_d = S_PUT;
				end
			end
			Q_CLAMP: begin
				xlo_d = ax.lo; xhi_d = ax.hi;
				ylo_d = ay.lo; yhi_d = ay.hi;
				state_d = (ax.empty || ay.empty) ? Q_OUT : Q_START;
			end
			Q_START: begin
				row_d = 13'(ylo_q) * 13'(w_q);
				x_d = xlo_q;
				y_d = ylo_q;
				state_d = Q_CELL;
			end
			Q_CELL: begin
				cell_d = qcell;
				if (32'(qcell) < GRID_CELLS) begin
					fill_raddr = FAW'(qcell);
					state_d = Q_FILL;
				end else begin
					adv = 1'b1;
				end
			end
			Q_FILL: begin
				n_d = n;
				i_d = '0;
				if (n == '0) begin
					adv = 1'b1;
				end else begin
					ent_raddr = eaddr(cell_q, 0);
					state_d = Q_ENT;
				end
			end
			Q_ENT: begin
				ent_d = ent_rdata;
				slot_raddr = ent_rdata.chain;
				state_d = Q_SLOT;
			end
			Q_SLOT: begin
				if (slot_rdata[6]) begin
					// New chain: take the next gathered slot if any is left
					if (32'(cnt_q) < MAX_CHAINS) begin
						slot_we = 1'b1;
						slot_waddr = ent_q.chain;
						slot_wdata = 7'(cnt_q);
						gath_we = 1'b1;
						gath_waddr = GAW'(cnt_q);
						gath_wdata = ent_q;
						cnt_d = cnt_q + 1'b1;
					end
					nent = 1'b1;
				end else if (32'(slot_rdata) < 32'(cnt_q)) begin
					gath_raddr = GAW'(slot_rdata[5:0]);
					s_d = GAW'(slot_rdata[5:0]);
					state_d = Q_MRG;
				end else begin
					nent = 1'b1;
				end
			end
			Q_MRG: begin
				// Merge the entry range into the gathered one
				if (ent_q.rstart < m.rstart) begin
					m.rstart = ent_q.rstart;
				end
				if (ent_q.rend > m.rend) begin
					m.rend = ent_q.rend;
				end
				gath_we = 1'b1;
				gath_waddr = s_q;
				gath_wdata = m;
				nent = 1'b1;
			end
			Q_OUT: begin
				if (cnt_q == '0) begin
					pchain_d = '0; pstart_d = '0; pend_d = '0;
					pstat_d = ST_APPENDED;
					state_d = S_PUT;
				end else begin
					k_d = '0;
					state_d = Q_EWAIT;
				end
			end
			Q_EWAIT: begin
				state_d = Q_EMIT;
			end
			Q_EMIT: begin
				// Emit one gathered word and free its chain slot
				if (out_free) begin
					out_load = 1'b1;
					ochain_d = gath_rdata.chain;
					ostart_d = gath_rdata.rstart;
					oend_d = gath_rdata.rend;
					ofound_d = 1'b1;
					olast_d = (k_q + 1'b1 == cnt_q);
					slot_we = 1'b1;
					slot_waddr = gath_rdata.chain;
					slot_wdata = SLOT_FREE;
					if (k_q + 1'b1 == cnt_q) begin
						state_d = S_IDLE;
					end else begin
						k_d = k_q + 1'b1;
						gath_raddr = GAW'(k_q + 1'b1);
						state_d = Q_EWAIT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Advance to the next entry of the cell
		if (nent) begin
			if (32'(i_q) + 1 < 32'(n_q)) begin
				i_d = i_q + 1'b1;
				ent_raddr = eaddr(cell_q, 32'(i_q) + 1);
				state_d = Q_ENT;
			end else begin
				adv = 1'b1;
			end
		end

		// Advance to the next covered cell
		if (adv) begin
			if (x_q + 7'd1 == xhi_q) begin
				x_d = xlo_q;
				y_d = y_q + 7'd1;
				row_d = row_q + {6'b0, w_q};
				state_d = (y_q + 7'd1 == yhi_q) ? Q_OUT : Q_CELL;
			end else begin
				x_d = x_q + 7'd1;
				state_d = Q_CELL;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			w_q <= GRID_DIM_MAX;
			h_q <= GRID_DIM_MAX;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			cnt_q <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ORIGIN_X: ox_q <= $signed(cfg_data);
					CFG_ORIGIN_Y: oy_q <= $signed(cfg_data);
					CFG_WIDTH:    w_q <= clamp_dim(cfg_data);
					CFG_HEIGHT:   h_q <= clamp_dim(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// Working and payload registers
	always_ff @(posedge clk) begin
		cell_q <= cell_d;
		chain_q <= chain_d;
		edge_q <= edge_d;
		n_q <= n_d;
		i_q <= i_d;
		k_q <= k_d;
		s_q <= s_d;
		ent_q <= ent_d;
		x0_q <= x0_d; x1_q <= x1_d; y0_q <= y0_d; y1_q <= y1_d;
		xlo_q <= xlo_d; xhi_q <= xhi_d; ylo_q <= ylo_d; yhi_q <= yhi_d;
		x_q <= x_d; y_q <= y_d; row_q <= row_d;
		pchain_q <= pchain_d; pstart_q <= pstart_d; pend_q <= pend_d; pstat_q <= pstat_d;
		if (out_load) begin
			chain_out_q <= ochain_d;
			range_start_q <= ostart_d;
			range_end_q <= oend_d;
			found_q <= ofound_d;
			status_q <= ostat_d;
			last_q <= olast_d;
		end
	end

	assign out_valid = out_valid_q;
	assign chain_out = chain_out_q;
	assign range_start = range_start_q;
	assign range_end = range_end_q;
	assign found = found_q;
	assign status = status_q;
	assign last = last_q;

endmodule

FILE: rtl/gecq_checker.sv
module gecq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  chain_out,
	input logic [15:0] range_start,
	input logic [16:0] range_end,
	input logic        found,
	input logic [1:0]  status,
	input logic        last
);
	import gecq_pkg::*;

	// Hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chain_out) &&
		$stable(range_start) && $stable(range_end) && $stable(last))
		else $error("stalled output word changed");

	// Query words carry a good status and a nonempty range
	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_APPENDED &&
		range_end > {1'b0, range_start})
		else $error("bad query word");

	// Add words are always the last of their item
	a_add_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("add word without last");

	// Rejected adds carry an empty range
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_BAD) |->
		range_start == 16'd0 && range_end == 17'd0)
		else $error("rejected add with range");

endmodule

bind grid_edge_chain_query_unit gecq_checker u_gecq_checker (.*);
